[hdl/lfbl_pkg.sv]
package lfbl_pkg;

    // Width of the internal byte position counter; positions wrap at this width
    localparam int POSITION_BITS = 48;
    // Width of the reported positions
    localparam int OUT_BITS = 48;
    // Remaining count: wide enough for the 31-bit block length
    localparam int COUNT_BITS = 31;
    // Size word bytes kept before the last one arrives
    localparam int SIZE_KEEP_BITS = 24;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [7:0] HEADER_LENGTH_RESET = 8'd7;
    localparam logic [COUNT_BITS-1:0] CHECKSUM_BYTES = COUNT_BITS'(4);

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_SIZE     = 3'd1,
        PH_CONTENT  = 3'd2,
        PH_CHECKSUM = 3'd3,
        PH_DONE     = 3'd4
    } t_phase;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HEADER_LENGTH  = CFG_INDEX_BITS'(0),
        CFG_BLOCK_CHECKSUM = CFG_INDEX_BITS'(1)
    } t_cfg_index;

    typedef struct packed {
        logic                is_compressed;
        logic [OUT_BITS-1:0] start_position;
        logic [OUT_BITS-1:0] end_position;
        logic                end_mark;
    } t_desc;

    // Map an internal position onto the reported width
    function automatic logic [OUT_BITS-1:0] to_out(input logic [POSITION_BITS-1:0] pos);
        return OUT_BITS'(pos);
    endfunction

endpackage

[hdl/lfbl_if.sv]
interface lfbl_byte_if;
    import lfbl_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface lfbl_desc_if;
    import lfbl_pkg::*;

    logic                valid;
    logic                ready;
    logic                is_compressed;
    logic [OUT_BITS-1:0] start_position;
    logic [OUT_BITS-1:0] end_position;
    logic                end_mark;

    modport source (output valid, output is_compressed, output start_position,
                    output end_position, output end_mark, input ready);
    modport sink   (input valid, input is_compressed, input start_position,
                    input end_position, input end_mark, output ready);
endinterface

interface lfbl_cfg_if;
    import lfbl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/lz4_frame_block_locator_top.sv]
// LZ4 frame block locator. Takes one frame byte per clock on i_byte and reports
// one descriptor per data block on o_desc: compressed flag, absolute start
// position and one-past-end position, plus the end mark for the zero-length
// size word (start equals end). A byte is handled in the cycle it is accepted;
// its descriptor, if any, appears in the output register on the next cycle, so
// the sustained rate is one byte per clock. The input stalls only while a
// descriptor sits in the output register and o_desc.ready is low. After the end
// mark all bytes are accepted and dropped until reset. Configuration writes on
// i_cfg are always taken; change them only while the stream is idle.
module lz4_frame_block_locator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lfbl_byte_if.sink    i_byte,
    lfbl_desc_if.source  o_desc,
    lfbl_cfg_if.sink     i_cfg
);
    import lfbl_pkg::*;

    // Configuration registers
    logic [7:0]                r_header_length;
    logic                      r_checksum_present;

    // Parser state
    t_phase                    r_phase, n_phase;
    logic [POSITION_BITS-1:0]  r_pos;
    logic [COUNT_BITS-1:0]     r_remain, n_remain;
    logic [SIZE_KEEP_BITS-1:0] r_size, n_size;
    logic [POSITION_BITS-1:0]  r_begin, n_begin;
    logic                      r_comp, n_comp;

    // Output register
    logic                      r_out_valid;
    t_desc                     r_desc, n_desc;
    logic                      w_emit;

    logic                      w_in_fire;
    logic                      w_hdr_done;
    t_phase                    w_phase_eff;
    logic [COUNT_BITS-1:0]     w_cnt_eff;
    logic [1:0]                w_size_idx;
    logic [31:0]               w_size_word;
    logic [COUNT_BITS-1:0]     w_len;
    logic [POSITION_BITS-1:0]  w_next;

    // Handshakes
    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = !r_out_valid || o_desc.ready;
    assign w_in_fire    = i_byte.valid && i_byte.ready;

    // Header skip ends when the skipped count reaches the configured length;
    // the current byte is then the first size byte
    assign w_hdr_done  = (r_phase == PH_HEADER) && !(r_remain[7:0] < r_header_length);
    assign w_phase_eff = w_hdr_done ? PH_SIZE : r_phase;
    assign w_cnt_eff   = w_hdr_done ? '0 : r_remain;
    assign w_size_idx  = w_cnt_eff[1:0];
    assign w_size_word = {i_byte.stream_byte, r_size};
    assign w_len       = w_size_word[COUNT_BITS-1:0];
    assign w_next      = r_pos + POSITION_BITS'(1);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (w_phase_eff)
            PH_HEADER: begin
                n_phase = PH_HEADER;
            end
            PH_SIZE: begin
                n_phase = PH_SIZE;
                if (w_size_idx == 2'd3) begin
                    n_phase = (w_len == '0) ? PH_DONE : PH_CONTENT;
                end
            end
            PH_CONTENT: begin
                if (r_remain == COUNT_BITS'(1)) begin
                    n_phase = r_checksum_present ? PH_CHECKSUM : PH_SIZE;
                end
            end
            PH_CHECKSUM: begin
                if (r_remain == COUNT_BITS'(1)) begin
                    n_phase = PH_SIZE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Counters, size word assembly and descriptor
    always_comb begin
        n_remain = w_cnt_eff;
        n_size   = r_size;
        n_begin  = r_begin;
        n_comp   = r_comp;
        w_emit   = 1'b0;
        n_desc   = '{is_compressed:  r_comp,
                     start_position: to_out(r_begin),
                     end_position:   to_out(w_next),
                     end_mark:       1'b0};
        unique case (w_phase_eff)
            PH_HEADER: begin
                n_remain = w_cnt_eff + COUNT_BITS'(1);
            end
            PH_SIZE: begin
                n_remain = w_cnt_eff + COUNT_BITS'(1);
                unique case (w_size_idx)
                    2'd0: n_size[7:0]   = i_byte.stream_byte;
                    2'd1: n_size[15:8]  = i_byte.stream_byte;
                    2'd2: n_size[23:16] = i_byte.stream_byte;
                    2'd3: n_size        = r_size;
                    default: n_size     = r_size;
                endcase
                if (w_size_idx == 2'd3) begin
                    n_comp  = !i_byte.stream_byte[7];
                    n_begin = w_next;
                    if (w_len == '0) begin
                        // End mark: report at once with start equal to end
                        w_emit   = 1'b1;
                        n_remain = '0;
                        n_desc   = '{is_compressed:  !i_byte.stream_byte[7],
                                     start_position: to_out(w_next),
                                     end_position:   to_out(w_next),
                                     end_mark:       1'b1};
                    end else begin
                        n_remain = w_len;
                    end
                end
            end
            PH_CONTENT: begin
                n_remain = r_remain - COUNT_BITS'(1);
                if (r_remain == COUNT_BITS'(1)) begin
                    w_emit = 1'b1;
                    if (r_checksum_present) begin
                        n_remain = CHECKSUM_BYTES;
                    end
                end
            end
            PH_CHECKSUM: begin
                n_remain = r_remain - COUNT_BITS'(1);
            end
            PH_DONE: begin
                n_remain = r_remain;
            end
            default: begin
                n_remain = r_remain;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length    <= HEADER_LENGTH_RESET;
            r_checksum_present <= 1'b0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_HEADER_LENGTH) begin
                r_header_length <= i_cfg.data;
            end else if (i_cfg.index == CFG_BLOCK_CHECKSUM) begin
                r_checksum_present <= i_cfg.data[0];
            end
        end
    end

    // Advance parser state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_remain <= '0;
            r_begin  <= '0;
            r_comp   <= 1'b0;
        end else if (w_in_fire) begin
            r_phase  <= n_phase;
            r_pos    <= w_next;
            r_remain <= n_remain;
            r_begin  <= n_begin;
            r_comp   <= n_comp;
        end
    end

    // Size word bytes carry no reset: every byte is rewritten before use
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_size <= n_size;
        end
    end

    // Output register: load on emit, drop on downstream accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_desc.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_emit) begin
            r_desc <= n_desc;
        end
    end

    assign o_desc.valid          = r_out_valid;
    assign o_desc.is_compressed  = r_desc.is_compressed;
    assign o_desc.start_position = r_desc.start_position;
    assign o_desc.end_position   = r_desc.end_position;
    assign o_desc.end_mark       = r_desc.end_mark;

endmodule

[hdl/lfbl_checker.sv]
module lfbl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [lfbl_pkg::OUT_BITS-1:0] i_start,
    input logic [lfbl_pkg::OUT_BITS-1:0] i_end,
    input logic                          i_end_mark
);
    import lfbl_pkg::*;

    // A held descriptor stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("descriptor dropped while stalled");

    // A new descriptor only follows an accepted byte
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !$past(i_out_valid && !i_out_ready)) |->
            $past(i_in_valid && i_in_ready))
        else $error("descriptor without a byte");

    // Input must stall while a descriptor waits
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("byte taken while output full");

    // End mark has zero length, data blocks do not
    a_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_start == i_end) == i_end_mark))
        else $error("block length inconsistent with end mark");

endmodule

bind lz4_frame_block_locator_top lfbl_checker u_lfbl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_desc.valid),
    .i_out_ready (o_desc.ready),
    .i_start     (o_desc.start_position),
    .i_end       (o_desc.end_position),
    .i_end_mark  (o_desc.end_mark)
);
